// File: rtl/iaw_pkg.sv
// ----------------------------------------------------------------------------
// iaw_pkg
// Shared types and constants for the im2row address walker.
// ----------------------------------------------------------------------------
package iaw_pkg;

    // default sizes
    localparam int DIM_BITS_DEF   = 16;
    localparam int INDEX_BITS_DEF = 32;

    // configuration register map
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 32;
    localparam int COUNT_BITS    = 16;

    localparam logic [CFG_IDX_BITS-1:0] CFG_INPUT_DIMS    = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_OUTPUT_DIMS   = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_KERNEL_DIMS   = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_STRIDE_PAIR   = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_PADDING_PAIR  = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DILATION_PAIR = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CHANNEL_COUNT = 3'd6;
    localparam logic [CFG_IDX_BITS-1:0] CFG_BATCH_COUNT   = 3'd7;

    localparam logic [CFG_DATA_BITS-1:0] PAIR_ONE_RESET  = 32'h0001_0001;
    localparam logic [CFG_DATA_BITS-1:0] PAIR_ZERO_RESET = 32'h0000_0000;
    localparam logic [COUNT_BITS-1:0]    COUNT_RESET     = 16'd1;

    // walk counters, innermost first
    localparam int NUM_CNT   = 6;
    localparam int CNT_CHAN  = 0;
    localparam int CNT_KCOL  = 1;
    localparam int CNT_KROW  = 2;
    localparam int CNT_OCOL  = 3;
    localparam int CNT_OROW  = 4;
    localparam int CNT_BATCH = 5;

    // multiply-add sequence, one step per cycle
    localparam int STEP_BITS = 4;
    localparam logic [STEP_BITS-1:0] STEP_ROW_MUL = 4'd0;
    localparam logic [STEP_BITS-1:0] STEP_ROW_ADD = 4'd1;
    localparam logic [STEP_BITS-1:0] STEP_COL_MUL = 4'd2;
    localparam logic [STEP_BITS-1:0] STEP_COL_ADD = 4'd3;
    localparam logic [STEP_BITS-1:0] STEP_CHECK   = 4'd4;
    localparam logic [STEP_BITS-1:0] STEP_SRC_H   = 4'd5;
    localparam logic [STEP_BITS-1:0] STEP_SRC_W   = 4'd6;
    localparam logic [STEP_BITS-1:0] STEP_SRC_C   = 4'd7;
    localparam logic [STEP_BITS-1:0] STEP_DST_OH  = 4'd8;
    localparam logic [STEP_BITS-1:0] STEP_DST_OW  = 4'd9;
    localparam logic [STEP_BITS-1:0] STEP_DST_C   = 4'd10;
    localparam logic [STEP_BITS-1:0] STEP_DST_KH  = 4'd11;
    localparam logic [STEP_BITS-1:0] STEP_DST_KW  = 4'd12;
    localparam logic [STEP_BITS-1:0] STEP_FIRST   = STEP_ROW_MUL;
    localparam logic [STEP_BITS-1:0] STEP_LAST    = STEP_DST_KW;

    typedef struct packed {
        logic [CFG_DATA_BITS-1:0] input_dims;
        logic [CFG_DATA_BITS-1:0] output_dims;
        logic [CFG_DATA_BITS-1:0] kernel_dims;
        logic [CFG_DATA_BITS-1:0] stride_pair;
        logic [CFG_DATA_BITS-1:0] padding_pair;
        logic [CFG_DATA_BITS-1:0] dilation_pair;
        logic [COUNT_BITS-1:0]    channel_count;
        logic [COUNT_BITS-1:0]    batch_count;
    } cfg_t;

    typedef struct packed {
        logic                 clear;   // zero the walk counters
        logic                 run;     // perform one multiply-add step
        logic [STEP_BITS-1:0] step;
        logic                 finish;  // load result, advance counters
    } dp_cmd_t;

    typedef struct packed {
        logic empty;                   // some loop bound is zero
    } dp_sts_t;

endpackage

// File: rtl/iaw_cfg.sv
// ----------------------------------------------------------------------------
// iaw_cfg
// Configuration register bank, write only.
// ----------------------------------------------------------------------------
module iaw_cfg (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_wr_en,
    input  logic [iaw_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [iaw_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    output iaw_pkg::cfg_t                      cfg
);
    import iaw_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_INPUT_DIMS:    cfg_next.input_dims    = cfg_data;
                CFG_OUTPUT_DIMS:   cfg_next.output_dims   = cfg_data;
                CFG_KERNEL_DIMS:   cfg_next.kernel_dims   = cfg_data;
                CFG_STRIDE_PAIR:   cfg_next.stride_pair   = cfg_data;
                CFG_PADDING_PAIR:  cfg_next.padding_pair  = cfg_data;
                CFG_DILATION_PAIR: cfg_next.dilation_pair = cfg_data;
                CFG_CHANNEL_COUNT: cfg_next.channel_count = cfg_data[COUNT_BITS-1:0];
                CFG_BATCH_COUNT:   cfg_next.batch_count   = cfg_data[COUNT_BITS-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.input_dims    <= PAIR_ONE_RESET;
            cfg_reg.output_dims   <= PAIR_ONE_RESET;
            cfg_reg.kernel_dims   <= PAIR_ONE_RESET;
            cfg_reg.stride_pair   <= PAIR_ONE_RESET;
            cfg_reg.padding_pair  <= PAIR_ZERO_RESET;
            cfg_reg.dilation_pair <= PAIR_ONE_RESET;
            cfg_reg.channel_count <= COUNT_RESET;
            cfg_reg.batch_count   <= COUNT_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: rtl/iaw_datapath.sv
// ----------------------------------------------------------------------------
// iaw_datapath
// Walk counters, shared multiply-add unit and result register.
// ----------------------------------------------------------------------------
module iaw_datapath #(
    parameter int DIM_BITS   = iaw_pkg::DIM_BITS_DEF,
    parameter int INDEX_BITS = iaw_pkg::INDEX_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  iaw_pkg::cfg_t         cfg,
    input  iaw_pkg::dp_cmd_t      cmd,
    output iaw_pkg::dp_sts_t      sts,
    output logic [INDEX_BITS-1:0] src_index,
    output logic [INDEX_BITS-1:0] dst_index,
    output logic                  write,
    output logic                  last
);
    import iaw_pkg::*;

    // wide enough for stride*pos + dilation*pos and for an index
    localparam int ACC_W  = (INDEX_BITS > 2*DIM_BITS + 1) ? INDEX_BITS : 2*DIM_BITS + 1;
    localparam int PROD_W = INDEX_BITS + DIM_BITS;

    // dimension fields
    logic [DIM_BITS-1:0] ih, iw, oh, ow, kh, kw;
    logic [DIM_BITS-1:0] vs, hs, vp, hp, vd, hd, nc, nb;

    assign ih = cfg.input_dims[16 +: DIM_BITS];
    assign iw = cfg.input_dims[DIM_BITS-1:0];
    assign oh = cfg.output_dims[16 +: DIM_BITS];
    assign ow = cfg.output_dims[DIM_BITS-1:0];
    assign kh = cfg.kernel_dims[16 +: DIM_BITS];
    assign kw = cfg.kernel_dims[DIM_BITS-1:0];
    assign vs = cfg.stride_pair[16 +: DIM_BITS];
    assign hs = cfg.stride_pair[DIM_BITS-1:0];
    assign vp = cfg.padding_pair[16 +: DIM_BITS];
    assign hp = cfg.padding_pair[DIM_BITS-1:0];
    assign vd = cfg.dilation_pair[16 +: DIM_BITS];
    assign hd = cfg.dilation_pair[DIM_BITS-1:0];
    assign nc = cfg.channel_count[DIM_BITS-1:0];
    assign nb = cfg.batch_count[DIM_BITS-1:0];

    assign sts.empty = (nb == '0) || (oh == '0) || (ow == '0) ||
                       (kh == '0) || (kw == '0) || (nc == '0);

    // ---------------- walk counters ----------------
    logic [DIM_BITS-1:0] cnt_reg   [NUM_CNT];
    logic [DIM_BITS-1:0] cnt_next  [NUM_CNT];
    logic [DIM_BITS-1:0] cnt_bound [NUM_CNT];
    logic [DIM_BITS:0]   cnt_inc   [NUM_CNT];
    logic [NUM_CNT-1:0]  cnt_wrap;
    logic [NUM_CNT:0]    carry;

    assign cnt_bound[CNT_CHAN]  = nc;
    assign cnt_bound[CNT_KCOL]  = kw;
    assign cnt_bound[CNT_KROW]  = kh;
    assign cnt_bound[CNT_OCOL]  = ow;
    assign cnt_bound[CNT_OROW]  = oh;
    assign cnt_bound[CNT_BATCH] = nb;

    // ripple carry from channel outwards; a counter at or past bound-1 wraps
    always_comb
    begin
        carry[0] = 1'b1;
        for (int i = 0; i < NUM_CNT; i++)
        begin
            cnt_inc[i]  = {1'b0, cnt_reg[i]} + 1'b1;
            cnt_wrap[i] = cnt_inc[i] >= {1'b0, cnt_bound[i]};
            if (carry[i])
                cnt_next[i] = cnt_wrap[i] ? '0 : cnt_inc[i][DIM_BITS-1:0];
            else
                cnt_next[i] = cnt_reg[i];
            carry[i+1] = carry[i] & cnt_wrap[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CNT; i++)
                cnt_reg[i] <= '0;
        end
        else if (cmd.clear)
        begin
            for (int i = 0; i < NUM_CNT; i++)
                cnt_reg[i] <= '0;
        end
        else if (cmd.finish)
        begin
            for (int i = 0; i < NUM_CNT; i++)
                cnt_reg[i] <= cnt_next[i];
        end
    end

    // ---------------- multiply-add unit ----------------
    logic [ACC_W-1:0]      acc_reg;
    logic [INDEX_BITS-1:0] acc_lo;
    logic [INDEX_BITS-1:0] mul_x;
    logic [DIM_BITS-1:0]   mul_y;
    logic [ACC_W-1:0]      add_z;
    logic [PROD_W-1:0]     mul_p;
    logic [ACC_W-1:0]      mac_res;

    logic [ACC_W-1:0]    rsum_reg, csum_reg;
    logic [ACC_W-1:0]    row_diff, col_diff;
    logic                row_ok, col_ok;
    logic [DIM_BITS-1:0] ir_reg, ic_reg;
    logic                inside_reg;
    logic [INDEX_BITS-1:0] src_reg;

    assign acc_lo = acc_reg[INDEX_BITS-1:0];

    always_comb
    begin
        mul_x = '0;
        mul_y = '0;
        add_z = '0;
        unique case (cmd.step)
            STEP_ROW_MUL:
            begin
                mul_x = INDEX_BITS'(cnt_reg[CNT_OROW]);
                mul_y = vs;
            end
            STEP_ROW_ADD:
            begin
                mul_x = INDEX_BITS'(cnt_reg[CNT_KROW]);
                mul_y = vd;
                add_z = acc_reg;
            end
            STEP_COL_MUL:
            begin
                mul_x = INDEX_BITS'(cnt_reg[CNT_OCOL]);
                mul_y = hs;
            end
            STEP_COL_ADD:
            begin
                mul_x = INDEX_BITS'(cnt_reg[CNT_KCOL]);
                mul_y = hd;
                add_z = acc_reg;
            end
            STEP_CHECK:
            begin
                mul_x = '0;
            end
            STEP_SRC_H:
            begin
                mul_x = INDEX_BITS'(cnt_reg[CNT_BATCH]);
                mul_y = ih;
                add_z = ACC_W'(ir_reg);
            end
            STEP_SRC_W:
            begin
                mul_x = acc_lo;
                mul_y = iw;
                add_z = ACC_W'(ic_reg);
            end
            STEP_SRC_C:
            begin
                mul_x = acc_lo;
                mul_y = nc;
                add_z = ACC_W'(cnt_reg[CNT_CHAN]);
            end
            STEP_DST_OH:
            begin
                mul_x = INDEX_BITS'(cnt_reg[CNT_BATCH]);
                mul_y = oh;
                add_z = ACC_W'(cnt_reg[CNT_OROW]);
            end
            STEP_DST_OW:
            begin
                mul_x = acc_lo;
                mul_y = ow;
                add_z = ACC_W'(cnt_reg[CNT_OCOL]);
            end
            STEP_DST_C:
            begin
                mul_x = acc_lo;
                mul_y = nc;
                add_z = ACC_W'(cnt_reg[CNT_CHAN]);
            end
            STEP_DST_KH:
            begin
                mul_x = acc_lo;
                mul_y = kh;
                add_z = ACC_W'(cnt_reg[CNT_KROW]);
            end
            STEP_DST_KW:
            begin
                mul_x = acc_lo;
                mul_y = kw;
                add_z = ACC_W'(cnt_reg[CNT_KCOL]);
            end
            default:
            begin
                mul_x = '0;
            end
        endcase
    end

    assign mul_p   = mul_x * mul_y;
    assign mac_res = ACC_W'(mul_p) + add_z;

    // tap position minus padding, and bounds test
    assign row_diff = rsum_reg - ACC_W'(vp);
    assign col_diff = csum_reg - ACC_W'(hp);
    assign row_ok   = (rsum_reg >= ACC_W'(vp)) && (row_diff < ACC_W'(ih));
    assign col_ok   = (csum_reg >= ACC_W'(hp)) && (col_diff < ACC_W'(iw));

    always_ff @(posedge clk)
    begin
        if (cmd.run)
        begin
            acc_reg <= mac_res;
            if (cmd.step == STEP_ROW_ADD)
                rsum_reg <= mac_res;
            if (cmd.step == STEP_COL_ADD)
                csum_reg <= mac_res;
            if (cmd.step == STEP_CHECK)
            begin
                ir_reg     <= row_diff[DIM_BITS-1:0];
                ic_reg     <= col_diff[DIM_BITS-1:0];
                inside_reg <= row_ok & col_ok;
            end
            if (cmd.step == STEP_SRC_C)
                src_reg <= inside_reg ? mac_res[INDEX_BITS-1:0] : '0;
        end
    end

    // ---------------- result register ----------------
    logic [INDEX_BITS-1:0] src_index_reg, dst_index_reg;
    logic                  write_reg, last_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            src_index_reg <= src_reg;
            dst_index_reg <= acc_lo;
            write_reg     <= inside_reg;
            last_reg      <= carry[NUM_CNT];
        end
    end

    assign src_index = src_index_reg;
    assign dst_index = dst_index_reg;
    assign write     = write_reg;
    assign last      = last_reg;

    // end of walk leaves every counter at zero
    a_wrap_to_zero: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish && carry[NUM_CNT] |=>
            cnt_reg[CNT_CHAN] == '0 && cnt_reg[CNT_KCOL] == '0 &&
            cnt_reg[CNT_KROW] == '0 && cnt_reg[CNT_OCOL] == '0 &&
            cnt_reg[CNT_OROW] == '0 && cnt_reg[CNT_BATCH] == '0)
        else $error("counters not cleared after last element");

    // restart clears the counters
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear |=> cnt_reg[CNT_CHAN] == '0 && cnt_reg[CNT_BATCH] == '0 &&
                      cnt_reg[CNT_OROW] == '0 && cnt_reg[CNT_OCOL] == '0)
        else $error("restart did not clear counters");

    // padding taps carry a zero source index
    a_pad_src_zero: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish && !inside_reg |=> src_index == '0 && !write)
        else $error("padding tap with non-zero source index");

endmodule

// File: rtl/iaw_ctrl.sv
// ----------------------------------------------------------------------------
// iaw_ctrl
// Sequencer: accepts a beat, steps the multiply-add unit, posts the result.
// ----------------------------------------------------------------------------
module iaw_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic             restart,
    output logic             out_valid,
    input  logic             out_ready,
    output iaw_pkg::dp_cmd_t cmd,
    input  iaw_pkg::dp_sts_t sts
);
    import iaw_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]           state_reg, state_next;
    logic [STEP_BITS-1:0] step_reg, step_next;
    logic                 out_valid_reg, out_valid_next;
    logic                 in_beat;
    logic                 out_free;

    assign in_ready = (state_reg == ST_IDLE);
    assign in_beat  = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    assign cmd.clear  = in_beat && restart;
    assign cmd.run    = (state_reg == ST_RUN);
    assign cmd.step   = step_reg;
    assign cmd.finish = (state_reg == ST_DONE) && out_free;

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_beat && !sts.empty)
                begin
                    state_next = ST_RUN;
                    step_next  = STEP_FIRST;
                end
            end
            ST_RUN:
            begin
                step_next = STEP_BITS'(step_reg + 1'b1);
                if (step_reg == STEP_LAST)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.finish)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= STEP_FIRST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    // a finished result waits rather than overwrite an untaken one
    a_hold_done: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DONE && out_valid_reg && !out_ready |=> state_reg == ST_DONE)
        else $error("result overwritten before it was taken");

    // an empty walk gives no result
    a_empty_no_beat: assert property (@(posedge clk) disable iff (!rst_n)
        in_beat && sts.empty && !out_valid_reg |=> !out_valid_reg && state_reg == ST_IDLE)
        else $error("empty walk produced a result");

    // the sequence always runs to its last step before finishing
    a_seq_end: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_RUN && step_reg == STEP_LAST |=> state_reg == ST_DONE)
        else $error("step sequence did not complete");

    a_busy_no_take: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_RUN |-> !in_ready)
        else $error("input taken mid-sequence");

endmodule

// File: rtl/im2row_address_walker_unit.sv
// ----------------------------------------------------------------------------
// im2row_address_walker_unit
// Address generator for im2row convolution lowering: one source/destination
// index pair per beat, walking batch, output row, output column, kernel row,
// kernel column and channel (innermost).
// ----------------------------------------------------------------------------
//
//  channel | handshake             | payload
//  --------+-----------------------+------------------------------------------
//  in      | in_valid / in_ready   | restart
//  out     | out_valid / out_ready | src_index, dst_index, write, last
//  cfg     | cfg_wr_en             | cfg_index, cfg_data
//
//  Sequence: a beat is taken, then the single shared multiply-add unit runs
//  13 steps (tap row/column, bounds check, source index, destination index)
//  and the result is posted; only then is the next beat taken. A beat met
//  by a zero loop bound starts no steps and posts nothing.
//  Reset: counters at zero, registers at their documented defaults.
//  Stalls: the result register lets the next beat in while a result waits;
//  that beat is held at its final step until the result is taken.
//
module im2row_address_walker_unit #(
    parameter int DIM_BITS   = iaw_pkg::DIM_BITS_DEF,
    parameter int INDEX_BITS = iaw_pkg::INDEX_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // item in
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic                               restart,
    // item out
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [INDEX_BITS-1:0]              src_index,
    output logic [INDEX_BITS-1:0]              dst_index,
    output logic                               write,
    output logic                               last,
    // register writes
    input  logic                               cfg_wr_en,
    input  logic [iaw_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [iaw_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
    import iaw_pkg::*;

    cfg_t    cfg;
    dp_cmd_t cmd;
    dp_sts_t sts;

    // register bank; the user must write it only while the walker is idle; the bank has no guard for this
    iaw_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // sequencer: owns both handshakes and drives the datapath step by step
    iaw_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .restart   (restart),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    // counters, multiply-add unit and result register
    iaw_datapath #(
        .DIM_BITS   (DIM_BITS),
        .INDEX_BITS (INDEX_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .cmd       (cmd),
        .sts       (sts),
        .src_index (src_index),
        .dst_index (dst_index),
        .write     (write),
        .last      (last)
    );

endmodule

// File: verif/im2row_address_walker_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// im2row_address_walker_unit_tb
// Self-checking bench for the im2row address walker. A short table of directed
// beats covers reset defaults, empty walks, padding, counters left beyond
// lowered bounds, all-ones registers and index wrap. Random shapes follow,
// under three idling regimes and one long output hold-off. Each result is checked
// against a cycle-free model of the six nested counters or a typed table row.
// ----------------------------------------------------------------------------
module im2row_address_walker_unit_tb;

    import iaw_pkg::*;

    localparam int IDX_W         = INDEX_BITS_DEF;
    localparam int RANDOM_BEATS  = 1400;    // beats that yield a result
    localparam int SETTLE_CYCLES = 40;      // margin for a beat still inside the walker to finish
    localparam int HOLD_CYCLES   = 400;     // long output hold-off
    localparam int CYCLE_LIMIT   = 600000;

    typedef struct packed {
        logic [IDX_W-1:0] src;
        logic [IDX_W-1:0] dst;
        logic             wr;
        logic             lst;
    } addr_pair_t;

    typedef enum logic [1:0] {ROW_WRITE, ROW_BEAT, ROW_TYPED} row_kind_t;

    // one line of the directed table: a register write, a predicted beat, or
    // a beat whose outcome is typed in (yields = 0 means no result at all)
    typedef struct packed {
        row_kind_t                kind;
        logic [CFG_IDX_BITS-1:0]  reg_idx;
        logic [CFG_DATA_BITS-1:0] reg_val;
        logic                     rs;
        logic                     yields;
        addr_pair_t               want;
    } dir_row_t;

    logic                     clk = 1'b0;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_ready;
    logic                     restart;
    logic                     out_valid;
    logic                     out_ready;
    logic [IDX_W-1:0]         src_index;
    logic [IDX_W-1:0]         dst_index;
    logic                     write;
    logic                     last;
    logic                     cfg_wr_en;
    logic [CFG_IDX_BITS-1:0]  cfg_index;
    logic [CFG_DATA_BITS-1:0] cfg_data;

    // shadow of the register file and of the walk counters
    cfg_t             shape_regs;
    logic [15:0]      walk_pos [NUM_CNT];
    addr_pair_t       addr_q [$];
    dir_row_t         dir_tbl [$];

    int  send_gap_pct   = 6;
    int  recv_stall_pct = 81;
    bit  hold_request   = 1'b0;

    int  cycle_count     = 0;
    int  bad_results     = 0;
    int  results_checked = 0;
    int  beats_sent      = 0;
    int  empty_beats     = 0;
    int  padded_taps     = 0;
    int  walk_ends       = 0;
    int  shapes_used     = 0;

    im2row_address_walker_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .restart   (restart),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .src_index (src_index),
        .dst_index (dst_index),
        .write     (write),
        .last      (last),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Address model: one call per accepted beat. Returns 0 when some loop
    // bound is zero, in which case nothing is posted and the counters hold (or clear on restart).
    // ------------------------------------------------------------------------
    function automatic bit walk_step(input logic rs, output addr_pair_t res);
        longint ih, iw, oh, ow, kh, kw, nc, nb;
        longint vstr, hstr, vdil, hdil, vpad, hpad;
        longint b, orow, ocol, kr, kc, ch;
        longint ir, ic, src, row, col, dst;
        longint bnd [NUM_CNT];
        bit     in_bounds;
        bit     carry;
        res = '0;
        if (rs)
        begin
            foreach (walk_pos[k])
                walk_pos[k] = '0;
        end
        ih = shape_regs.input_dims[31:16];
        iw = shape_regs.input_dims[15:0];
        oh = shape_regs.output_dims[31:16];
        ow = shape_regs.output_dims[15:0];
        kh = shape_regs.kernel_dims[31:16];
        kw = shape_regs.kernel_dims[15:0];
        nc = shape_regs.channel_count;
        nb = shape_regs.batch_count;
        if (nb == 0 || oh == 0 || ow == 0 || kh == 0 || kw == 0 || nc == 0)
            return 1'b0;

        vstr = shape_regs.stride_pair[31:16];
        hstr = shape_regs.stride_pair[15:0];
        vdil = shape_regs.dilation_pair[31:16];
        hdil = shape_regs.dilation_pair[15:0];
        vpad = shape_regs.padding_pair[31:16];
        hpad = shape_regs.padding_pair[15:0];
        b    = walk_pos[CNT_BATCH];
        orow = walk_pos[CNT_OROW];
        ocol = walk_pos[CNT_OCOL];
        kr   = walk_pos[CNT_KROW];
        kc   = walk_pos[CNT_KCOL];
        ch   = walk_pos[CNT_CHAN];

        // tap position in the input; negative means top or left padding
        ir = vstr * orow + vdil * kr - vpad;
        ic = hstr * ocol + hdil * kc - hpad;
        in_bounds = (ir >= 0) && (ir < ih) && (ic >= 0) && (ic < iw);
        src = in_bounds ? (((b * ih + ir) * iw + ic) * nc + ch) : 0;
        row = (b * oh + orow) * ow + ocol;
        col = ch * kh * kw + kr * kw + kc;
        dst = row * nc * kh * kw + col;

        // innermost first; a counter at or past bound-1 wraps and carries
        bnd[CNT_CHAN]  = nc;
        bnd[CNT_KCOL]  = kw;
        bnd[CNT_KROW]  = kh;
        bnd[CNT_OCOL]  = ow;
        bnd[CNT_OROW]  = oh;
        bnd[CNT_BATCH] = nb;
        carry = 1'b1;
        for (int k = 0; k < NUM_CNT; k++)
        begin
            if (carry)
            begin
                if (longint'(walk_pos[k]) + 1 >= bnd[k])
                    walk_pos[k] = '0;
                else
                begin
                    walk_pos[k] = walk_pos[k] + 16'd1;
                    carry       = 1'b0;
                end
            end
        end

        res.src = src[IDX_W-1:0];
        res.dst = dst[IDX_W-1:0];
        res.wr  = in_bounds;
        res.lst = carry;
        return 1'b1;
    endfunction

    function automatic dir_row_t row_write(input logic [CFG_IDX_BITS-1:0] idx,
                                           input logic [CFG_DATA_BITS-1:0] val);
        dir_row_t r;
        r         = '0;
        r.kind    = ROW_WRITE;
        r.reg_idx = idx;
        r.reg_val = val;
        return r;
    endfunction

    function automatic dir_row_t row_beat(input logic rs);
        dir_row_t r;
        r      = '0;
        r.kind = ROW_BEAT;
        r.rs   = rs;
        return r;
    endfunction

    function automatic dir_row_t row_typed(input logic rs, input logic yields,
                                           input logic [IDX_W-1:0] src,
                                           input logic [IDX_W-1:0] dst,
                                           input logic wr, input logic lst);
        dir_row_t r;
        r          = '0;
        r.kind     = ROW_TYPED;
        r.rs       = rs;
        r.yields   = yields;
        r.want.src = src;
        r.want.dst = dst;
        r.want.wr  = wr;
        r.want.lst = lst;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Register write; only ever issued with the walker idle.
    // ------------------------------------------------------------------------
    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] val);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        case (idx)
            CFG_INPUT_DIMS:    shape_regs.input_dims    = val;
            CFG_OUTPUT_DIMS:   shape_regs.output_dims   = val;
            CFG_KERNEL_DIMS:   shape_regs.kernel_dims   = val;
            CFG_STRIDE_PAIR:   shape_regs.stride_pair   = val;
            CFG_PADDING_PAIR:  shape_regs.padding_pair  = val;
            CFG_DILATION_PAIR: shape_regs.dilation_pair = val;
            CFG_CHANNEL_COUNT: shape_regs.channel_count = val[COUNT_BITS-1:0];
            CFG_BATCH_COUNT:   shape_regs.batch_count   = val[COUNT_BITS-1:0];
            default: ;
        endcase
    endtask

    // ------------------------------------------------------------------------
    // Offer one beat and hold it until taken. Gaps are drawn per cycle before
    // the beat goes up. The address model runs at acceptance; a typed row
    // replaces the modelled outcome with the one written in the table.
    // ------------------------------------------------------------------------
    task automatic send_beat(input logic rs, input bit typed, input bit typed_yields,
                             input addr_pair_t typed_pair, output bit yields);
        addr_pair_t pair;
        @(negedge clk);
        while ($urandom_range(99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        restart  <= rs;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        yields = walk_step(rs, pair);
        if (typed)
        begin
            yields = typed_yields;
            pair   = typed_pair;
        end
        beats_sent++;
        if (yields)
            addr_q.push_back(pair);
        else
            empty_beats++;
    endtask

    // drop valid, let every pending result out, then give any result-free
    // beat still inside the walker time to finish
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (addr_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Receiver: random ready, or a long hold-off when one is requested.
    // ------------------------------------------------------------------------
    initial
    begin : receiver
        int hold_left;
        out_ready = 1'b0;
        hold_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                out_ready <= 1'b0;
                hold_left--;
            end
            else
                out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Result checker: every output beat against the oldest expectation.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        addr_pair_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (write === 1'b0)
                padded_taps++;
            if (last === 1'b1)
                walk_ends++;
            if (addr_q.size() == 0)
            begin
                bad_results++;
                if (bad_results <= 10)
                    $display("[%0t] result with none pending: src=%h dst=%h write=%b last=%b",
                             $realtime, src_index, dst_index, write, last);
            end
            else
            begin
                want = addr_q.pop_front();
                results_checked++;
                if (src_index !== want.src || dst_index !== want.dst ||
                    write !== want.wr || last !== want.lst)
                begin
                    bad_results++;
                    if (bad_results <= 10)
                        $display("[%0t] mismatch: src %h/%h dst %h/%h write %b/%b last %b/%b (exp/got)",
                                 $realtime, want.src, src_index, want.dst, dst_index,
                                 want.wr, write, want.lst, last);
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("im2row_address_walker_unit test failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        bit          yields;
        bit          wild;
        bit          pressure_done;
        int          produced;
        int          beats_in_shape;
        logic [31:0] val;

        in_valid      = 1'b0;
        restart       = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_index     = CFG_INPUT_DIMS;
        cfg_data      = '0;
        rst_n         = 1'b0;
        pressure_done = 1'b0;
        produced      = 0;

        shape_regs.input_dims    = PAIR_ONE_RESET;
        shape_regs.output_dims   = PAIR_ONE_RESET;
        shape_regs.kernel_dims   = PAIR_ONE_RESET;
        shape_regs.stride_pair   = PAIR_ONE_RESET;
        shape_regs.padding_pair  = PAIR_ZERO_RESET;
        shape_regs.dilation_pair = PAIR_ONE_RESET;
        shape_regs.channel_count = COUNT_RESET;
        shape_regs.batch_count   = COUNT_RESET;
        foreach (walk_pos[k])
            walk_pos[k] = '0;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // --- directed table ------------------------------------------------
        // reset shape is a one-element walk: every beat is also the last
        dir_tbl.push_back(row_typed(1'b0, 1'b1, '0, '0, 1'b1, 1'b1));
        dir_tbl.push_back(row_typed(1'b1, 1'b1, '0, '0, 1'b1, 1'b1));
        // zero channels: empty walk, nothing posted
        dir_tbl.push_back(row_write(CFG_CHANNEL_COUNT, 32'd0));
        dir_tbl.push_back(row_typed(1'b0, 1'b0, '0, '0, 1'b0, 1'b0));
        dir_tbl.push_back(row_typed(1'b1, 1'b0, '0, '0, 1'b0, 1'b0));
        // 2x2 image, 2x2 kernel, pad 1: first tap sits in the top-left pad
        dir_tbl.push_back(row_write(CFG_INPUT_DIMS,    32'h0002_0002));
        dir_tbl.push_back(row_write(CFG_OUTPUT_DIMS,   32'h0002_0002));
        dir_tbl.push_back(row_write(CFG_KERNEL_DIMS,   32'h0002_0002));
        dir_tbl.push_back(row_write(CFG_PADDING_PAIR,  32'h0001_0001));
        dir_tbl.push_back(row_write(CFG_CHANNEL_COUNT, 32'd2));
        dir_tbl.push_back(row_typed(1'b1, 1'b1, '0, '0, 1'b0, 1'b0));
        repeat (5) dir_tbl.push_back(row_beat(1'b0));
        // shrink the kernel mid-walk: kernel counters now past their bound
        dir_tbl.push_back(row_write(CFG_KERNEL_DIMS, 32'h0001_0001));
        repeat (2) dir_tbl.push_back(row_beat(1'b0));
        // every register at its top value except padding, which is zero
        dir_tbl.push_back(row_write(CFG_INPUT_DIMS,    32'hFFFF_FFFF));
        dir_tbl.push_back(row_write(CFG_OUTPUT_DIMS,   32'hFFFF_FFFF));
        dir_tbl.push_back(row_write(CFG_KERNEL_DIMS,   32'hFFFF_FFFF));
        dir_tbl.push_back(row_write(CFG_STRIDE_PAIR,   32'hFFFF_FFFF));
        dir_tbl.push_back(row_write(CFG_PADDING_PAIR,  32'h0000_0000));
        dir_tbl.push_back(row_write(CFG_DILATION_PAIR, 32'hFFFF_FFFF));
        dir_tbl.push_back(row_write(CFG_CHANNEL_COUNT, 32'h0000_FFFF));
        dir_tbl.push_back(row_write(CFG_BATCH_COUNT,   32'h0000_FFFF));
        dir_tbl.push_back(row_typed(1'b1, 1'b1, '0, '0, 1'b1, 1'b0));
        repeat (3) dir_tbl.push_back(row_beat(1'b0));
        // maximum padding puts the origin tap far outside
        dir_tbl.push_back(row_write(CFG_PADDING_PAIR, 32'hFFFF_FFFF));
        dir_tbl.push_back(row_typed(1'b1, 1'b1, '0, '0, 1'b0, 1'b0));
        // zero stride and dilation
        dir_tbl.push_back(row_write(CFG_STRIDE_PAIR,   32'h0000_0000));
        dir_tbl.push_back(row_write(CFG_DILATION_PAIR, 32'h0000_0000));
        dir_tbl.push_back(row_write(CFG_PADDING_PAIR,  32'h0000_0000));
        repeat (2) dir_tbl.push_back(row_beat(1'b0));
        // destination index wrap: step to a new output pixel, then widen
        // the kernel and channel count so the row pitch exceeds 32 bits
        dir_tbl.push_back(row_write(CFG_KERNEL_DIMS,   32'h0001_0001));
        dir_tbl.push_back(row_write(CFG_CHANNEL_COUNT, 32'd1));
        dir_tbl.push_back(row_write(CFG_OUTPUT_DIMS,   32'hFFFF_0002));
        dir_tbl.push_back(row_write(CFG_STRIDE_PAIR,   32'h0001_7FFF));
        dir_tbl.push_back(row_write(CFG_DILATION_PAIR, 32'h0001_0001));
        dir_tbl.push_back(row_typed(1'b1, 1'b1, '0, '0, 1'b1, 1'b0));
        dir_tbl.push_back(row_beat(1'b0));
        dir_tbl.push_back(row_write(CFG_KERNEL_DIMS,   32'hFFFF_FFFF));
        dir_tbl.push_back(row_write(CFG_CHANNEL_COUNT, 32'h0000_FFFF));
        dir_tbl.push_back(row_beat(1'b0));

        foreach (dir_tbl[i])
        begin
            if (dir_tbl[i].kind == ROW_WRITE)
            begin
                settle();
                write_reg(dir_tbl[i].reg_idx, dir_tbl[i].reg_val);
            end
            else
                send_beat(dir_tbl[i].rs, dir_tbl[i].kind == ROW_TYPED,
                          dir_tbl[i].yields, dir_tbl[i].want, yields);
        end

        // --- random shapes -------------------------------------------------
        // Mostly small tame shapes so walks complete and last flags show up;
        // one shape in eight is wild (zeros, all-ones, raw random words).
        // Counters are not restarted between shapes, so a smaller new shape
        // often starts with counters beyond their bounds.
        while (produced < RANDOM_BEATS)
        begin
            if (produced >= 2 * RANDOM_BEATS / 3)
            begin
                send_gap_pct   = 0;
                recv_stall_pct = 0;
            end
            else if (produced >= RANDOM_BEATS / 3)
            begin
                send_gap_pct   = 81;
                recv_stall_pct = 6;
            end
            settle();
            wild = ($urandom_range(7) == 0);
            for (int r = CFG_INPUT_DIMS; r <= CFG_BATCH_COUNT; r++)
            begin
                if (shapes_used == 0 || $urandom_range(3) != 0)
                begin
                    if (wild)
                    begin
                        case ($urandom_range(3))
                            0:       val = '0;
                            1:       val = '1;
                            2:       val = $urandom();
                            default: val = {16'($urandom_range(1, 3)),
                                            16'($urandom_range(1, 3))};
                        endcase
                    end
                    else
                    begin
                        case (r)
                            CFG_INPUT_DIMS:    val = {16'($urandom_range(1, 6)),
                                                      16'($urandom_range(1, 6))};
                            CFG_OUTPUT_DIMS:   val = {16'($urandom_range(1, 2)),
                                                      16'($urandom_range(1, 2))};
                            CFG_KERNEL_DIMS:   val = {16'($urandom_range(1, 3)),
                                                      16'($urandom_range(1, 3))};
                            CFG_STRIDE_PAIR:   val = {16'($urandom_range(0, 2)),
                                                      16'($urandom_range(0, 2))};
                            CFG_PADDING_PAIR:  val = {16'($urandom_range(0, 2)),
                                                      16'($urandom_range(0, 2))};
                            CFG_DILATION_PAIR: val = {16'($urandom_range(1, 2)),
                                                      16'($urandom_range(1, 2))};
                            CFG_CHANNEL_COUNT: val = 32'($urandom_range(1, 2));
                            default:           val = 32'($urandom_range(1, 2));
                        endcase
                    end
                    write_reg(r[CFG_IDX_BITS-1:0], val);
                end
            end
            shapes_used++;

            // with nobody idling, stop the receiver for a long stretch once
            // so the result register and the held beat both fill up
            if (!pressure_done && recv_stall_pct == 0 && send_gap_pct == 0)
            begin
                hold_request  = 1'b1;
                pressure_done = 1'b1;
            end

            beats_in_shape = $urandom_range(30, 90);
            repeat (beats_in_shape)
            begin
                send_beat($urandom_range(99) < 3, 1'b0, 1'b0, '0, yields);
                if (yields)
                    produced++;
            end
        end

        // --- wind down -----------------------------------------------------
        recv_stall_pct = 0;
        settle();

        $display("Covered %0d beats (%0d on empty walks) over %0d random shapes after the table;",
                 beats_sent, empty_beats, shapes_used);
        $display("%0d results checked, %0d padding taps, %0d walk ends, %0d bad results.",
                 results_checked, padded_taps, walk_ends, bad_results);
        if (bad_results == 0)
            $display("im2row_address_walker_unit test passed");
        else
            $display("im2row_address_walker_unit test failed");
        $finish;
    end

endmodule

// File: filelist.f
rtl/iaw_pkg.sv
rtl/iaw_cfg.sv
rtl/iaw_datapath.sv
rtl/iaw_ctrl.sv
rtl/im2row_address_walker_unit.sv
verif/im2row_address_walker_unit_tb.sv
